// ===== rtl/bdq_pkg.sv =====
`timescale 1ns / 1ps
// bdq_pkg: shared types for the bounded deque core
// request and status codes, controller states, command and status bundles

package bdq_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_DUMP       = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop;
    logic dump_start;
    logic dump_step;
    logic emit_empty;
    logic emit_full;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic dump_last;
  } stat_t;

endpackage

// ===== rtl/bounded_deque_push_pop_dump_core.sv =====
`timescale 1ns / 1ps
// bounded_deque_push_pop_dump_core: top level of the bounded deque
// joins bdq_ctrl and bdq_datapath; types come from bdq_pkg
//
// usage
//   a request beat is taken on a rising edge with start_i high and busy_o low:
//   req_type_i selects push front, push back, pop front or dump, value_i is
//   the element for a push and is ignored otherwise
//   every result beat sits on status_o, item_value_o and last_o for exactly one
//   cycle with res_valid_o high; the receiver has no way to stall it
// latency and throughput
//   push and pop give their single result the cycle after the request edge
//   (one registered read of the ring storage for a pop); a new request may
//   follow on the very next edge, so one request per cycle is sustained
//   a dump of n elements holds busy_o high while it walks, reading one storage
//   entry per cycle, and streams n result beats front to back, last_o on the
//   back element; a dump of an empty deque gives one empty-status beat
// reset
//   rst_ni clears the front index, the count and the result strobe; the
//   deque is empty afterwards and storage content is never read before it is
//   written, so the storage array itself is not cleared

module bounded_deque_push_pop_dump_core #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] value_i,
  output logic               res_valid_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] item_value_o,
  output logic               last_o
);

  // command and status bundles between the two halves
  bdq_pkg::cmd_t  cmd;
  bdq_pkg::stat_t stat;

  // request decode and dump walk
  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  // ring storage, indices and result registers
  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (value_i),
    .stat_o       (stat),
    .res_valid_o  (res_valid_o),
    .status_o     (status_o),
    .item_value_o (item_value_o),
    .last_o       (last_o)
  );

endmodule

// ===== rtl/bdq_ctrl.sv =====
`timescale 1ns / 1ps
// bdq_ctrl: request decode and dump sequencing for the bounded deque core
// depends on bdq_pkg for request codes, states and command bundles

module bdq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        req_type_i,
  input  bdq_pkg::stat_t    stat_i,
  output bdq_pkg::cmd_t     cmd_o,
  output logic              busy_o
);

  bdq_pkg::ctrl_state_e state_q, state_d;
  logic accept;

  assign accept = start_i && (state_q == bdq_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bdq_pkg::S_IDLE: begin
        if (accept && (bdq_pkg::req_e'(req_type_i) == bdq_pkg::REQ_DUMP) && !stat_i.empty) begin
          state_d = bdq_pkg::S_DUMP;
        end
      end
      bdq_pkg::S_DUMP: begin
        if (stat_i.dump_last) begin
          state_d = bdq_pkg::S_IDLE;
        end
      end
      default: state_d = bdq_pkg::S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b0;
    unique case (state_q)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (bdq_pkg::req_e'(req_type_i))
            bdq_pkg::REQ_PUSH_FRONT: begin
              cmd_o.emit_full  = stat_i.full;
              cmd_o.push_front = !stat_i.full;
            end
            bdq_pkg::REQ_PUSH_BACK: begin
              cmd_o.emit_full = stat_i.full;
              cmd_o.push_back = !stat_i.full;
            end
            bdq_pkg::REQ_POP_FRONT: begin
              cmd_o.emit_empty = stat_i.empty;
              cmd_o.pop        = !stat_i.empty;
            end
            bdq_pkg::REQ_DUMP: begin
              cmd_o.emit_empty = stat_i.empty;
              cmd_o.dump_start = !stat_i.empty;
            end
            default: cmd_o = '0;
          endcase
        end
      end
      bdq_pkg::S_DUMP: begin
        busy_o          = 1'b1;
        cmd_o.dump_step = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/bdq_datapath.sv =====
`timescale 1ns / 1ps
// bdq_datapath: ring buffer storage, front index, count and result registers
// depends on bdq_pkg for status codes and the command and status bundles

module bdq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bdq_pkg::cmd_t       cmd_i,
  input  logic signed [31:0]  value_i,
  output bdq_pkg::stat_t      stat_o,
  output logic                res_valid_o,
  output logic [1:0]          status_o,
  output logic signed [31:0]  item_value_o,
  output logic                last_o
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [31:0]      mem_q [DEPTH];
  logic [31:0]      rd_data_q;

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] dump_ptr_q, dump_ptr_d;
  logic [CNT_W-1:0] dump_k_q, dump_k_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q, out_status_d;
  logic             out_last_q, out_last_d;
  logic             out_sel_q, out_sel_d;

  logic [IDX_W-1:0] front_inc, front_dec, dump_ptr_inc, back_slot;
  logic [SUM_W-1:0] back_sum;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             dump_last;

  assign front_inc    = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign front_dec    = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
  assign dump_ptr_inc = (dump_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : dump_ptr_q + 1'b1;

  // back slot is front plus count, wrapped once
  assign back_sum  = SUM_W'(front_q) + SUM_W'(count_q);
  assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(back_sum);

  assign dump_last = (dump_k_q == count_q - 1'b1);

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CNT_W'(DEPTH));
  assign stat_o.dump_last = dump_last;

  assign wr_en   = cmd_i.push_front || cmd_i.push_back;
  assign wr_addr = cmd_i.push_front ? front_dec : back_slot;
  assign rd_en   = cmd_i.pop || cmd_i.dump_step;
  assign rd_addr = cmd_i.pop ? front_q : dump_ptr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    front_d      = front_q;
    count_d      = count_q;
    dump_ptr_d   = dump_ptr_q;
    dump_k_d     = dump_k_q;
    out_valid_d  = 1'b0;
    out_status_d = bdq_pkg::ST_OK;
    out_last_d   = 1'b1;
    out_sel_d    = 1'b0;

    if (cmd_i.push_front) begin
      front_d     = front_dec;
      count_d     = count_q + 1'b1;
      out_valid_d = 1'b1;
    end
    if (cmd_i.push_back) begin
      count_d     = count_q + 1'b1;
      out_valid_d = 1'b1;
    end
    if (cmd_i.pop) begin
      front_d     = front_inc;
      count_d     = count_q - 1'b1;
      out_valid_d = 1'b1;
      out_sel_d   = 1'b1;
    end
    if (cmd_i.emit_empty) begin
      out_valid_d  = 1'b1;
      out_status_d = bdq_pkg::ST_EMPTY;
    end
    if (cmd_i.emit_full) begin
      out_valid_d  = 1'b1;
      out_status_d = bdq_pkg::ST_FULL;
    end
    if (cmd_i.dump_start) begin
      dump_ptr_d = front_q;
      dump_k_d   = '0;
    end
    if (cmd_i.dump_step) begin
      dump_ptr_d  = dump_ptr_inc;
      dump_k_d    = dump_k_q + 1'b1;
      out_valid_d = 1'b1;
      out_sel_d   = 1'b1;
      out_last_d  = dump_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q      <= '0;
      count_q      <= '0;
      dump_ptr_q   <= '0;
      dump_k_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= bdq_pkg::ST_OK;
      out_last_q   <= 1'b0;
      out_sel_q    <= 1'b0;
    end else begin
      front_q      <= front_d;
      count_q      <= count_d;
      dump_ptr_q   <= dump_ptr_d;
      dump_k_q     <= dump_k_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
      out_sel_q    <= out_sel_d;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign last_o       = out_last_q;
  assign item_value_o = out_sel_q ? signed'(rd_data_q) : 32'sd0;

endmodule

// ===== tb/bounded_deque_push_pop_dump_core_tb.sv =====
`timescale 1ns / 1ps
// bounded_deque_push_pop_dump_core_tb: self-checking bench for the bounded deque core
// drives request beats with random gaps and checks every result beat against its own
// model of the deque; needs bdq_pkg and bounded_deque_push_pop_dump_core

module bounded_deque_push_pop_dump_core_tb;

  localparam int DEPTH       = 16;
  localparam int N_RANDOM    = 145;
  localparam int DRAIN_WAIT  = DEPTH + 8;     // quiet cycles after the last due beat
  localparam int CYCLE_LIMIT = 200000;

  // one request beat waiting to be driven, with its idle gap ahead of it
  typedef struct {
    bdq_pkg::req_e      req;
    logic signed [31:0] val;
    int unsigned        gap;
  } req_beat_t;

  // one result beat that the deque is due to produce
  typedef struct {
    bdq_pkg::status_e   status;
    logic signed [31:0] item;
    logic               last;
  } res_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [1:0]         req_type_i = bdq_pkg::REQ_PUSH_FRONT;
  logic signed [31:0] value_i = '0;
  logic               busy_o;
  logic               res_valid_o;
  logic [1:0]         status_o;
  logic signed [31:0] item_value_o;
  logic               last_o;

  req_beat_t   pending_reqs[$];
  res_beat_t   due_beats[$];
  int unsigned n_issued   = 0;
  int unsigned n_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  bit          no_gaps    = 1'b0;

  // bench copy of the deque: ring storage, front position and fill level
  logic signed [31:0] ring_mem [DEPTH];
  int unsigned        ring_front = 0;
  int unsigned        ring_count = 0;

  bounded_deque_push_pop_dump_core #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .res_valid_o (res_valid_o),
    .status_o    (status_o),
    .item_value_o(item_value_o),
    .last_o      (last_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  // push data: extremes and alternating patterns now and then, otherwise any word
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      4:       return 32'shaaaa_aaaa;
      5:       return 32'sh5555_5555;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_req(bdq_pkg::req_e req, logic signed [31:0] val);
    req_beat_t b;
    b.req = req;
    b.val = val;
    b.gap = pick_gap();
    pending_reqs.push_back(b);
    n_issued++;
  endfunction

  // --------------------------------------------------------------------------
  // deque predictor: updates the bench copy and queues the beats that are due
  // --------------------------------------------------------------------------

  function automatic void queue_beat(bdq_pkg::status_e st, logic signed [31:0] item,
                                     logic last);
    res_beat_t r;
    r.status = st;
    r.item   = item;
    r.last   = last;
    due_beats.push_back(r);
  endfunction

  function automatic void advance_deque(bdq_pkg::req_e req, logic signed [31:0] val);
    case (req)
      bdq_pkg::REQ_PUSH_FRONT: begin
        if (ring_count >= DEPTH) begin
          queue_beat(bdq_pkg::ST_FULL, '0, 1'b1);
        end else begin
          // front steps back one slot, wrapping below zero
          ring_front = (ring_front + DEPTH - 1) % DEPTH;
          ring_mem[ring_front] = val;
          ring_count++;
          queue_beat(bdq_pkg::ST_OK, '0, 1'b1);
        end
      end
      bdq_pkg::REQ_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          queue_beat(bdq_pkg::ST_FULL, '0, 1'b1);
        end else begin
          ring_mem[(ring_front + ring_count) % DEPTH] = val;
          ring_count++;
          queue_beat(bdq_pkg::ST_OK, '0, 1'b1);
        end
      end
      bdq_pkg::REQ_POP_FRONT: begin
        if (ring_count == 0) begin
          queue_beat(bdq_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          queue_beat(bdq_pkg::ST_OK, ring_mem[ring_front], 1'b1);
          ring_front = (ring_front + 1) % DEPTH;
          ring_count--;
        end
      end
      default: begin
        // dump: front to back, last flag on the back element only
        if (ring_count == 0) begin
          queue_beat(bdq_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned k = 0; k < ring_count; k++) begin
            queue_beat(bdq_pkg::ST_OK, ring_mem[(ring_front + k) % DEPTH],
                       k + 1 == ring_count);
          end
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // driver: holds a presented beat while busy, otherwise moves to the next one
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && busy_o)) begin
      // a presented beat with busy low has just been taken
      if (start_i) begin
        advance_deque(bdq_pkg::req_e'(req_type_i), value_i);
        n_accepted++;
      end
      if (pending_reqs.size() == 0) begin
        start_i <= 1'b0;
      end else if (pending_reqs[0].gap > 0) begin
        // idle cycle: junk on the request fields, start low
        pending_reqs[0].gap = pending_reqs[0].gap - 1;
        start_i    <= 1'b0;
        req_type_i <= 2'($urandom_range(0, 3));
        value_i    <= $urandom;
      end else begin
        start_i    <= 1'b1;
        req_type_i <= pending_reqs[0].req;
        value_i    <= pending_reqs[0].val;
        void'(pending_reqs.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: every strobed result beat against the oldest due beat
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    res_beat_t want;
    if (rst_ni && res_valid_o) begin
      if (due_beats.size() == 0) begin
        $display("%0t: stray result beat status %0d item %0d last %0d",
                 $time, status_o, item_value_o, last_o);
        mismatches++;
      end else begin
        want = due_beats.pop_front();
        if (status_o !== want.status || item_value_o !== want.item || last_o !== want.last)
        begin
          $display("%0t: expected status %0d item %0d last %0d, got %0d %0d %0d",
                   $time, want.status, want.item, want.last,
                   status_o, item_value_o, last_o);
          mismatches++;
        end
      end
    end
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: run guard expired, %0d beats still due", $time, due_beats.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------

  initial begin
    int unsigned   mode;
    int unsigned   r;
    bdq_pkg::req_e req;

    // directed: empty cases first, then extremes, fill to full, overflow both ends
    add_req(bdq_pkg::REQ_POP_FRONT, 32'sd7);
    add_req(bdq_pkg::REQ_DUMP, -32'sd1);
    add_req(bdq_pkg::REQ_PUSH_FRONT, 32'sh8000_0000);   // front wraps to the top slot
    add_req(bdq_pkg::REQ_PUSH_BACK, 32'sh7fff_ffff);
    add_req(bdq_pkg::REQ_PUSH_FRONT, '0);
    add_req(bdq_pkg::REQ_PUSH_BACK, -32'sd1);
    add_req(bdq_pkg::REQ_DUMP, '0);
    add_req(bdq_pkg::REQ_POP_FRONT, '0);
    for (int i = 0; i < 12; i++) begin
      add_req(i[0] ? bdq_pkg::REQ_PUSH_FRONT : bdq_pkg::REQ_PUSH_BACK,
              i[1] ? 32'shaaaa_aaaa : 32'sh5555_5555 ^ i);
    end
    add_req(bdq_pkg::REQ_PUSH_BACK, 32'sh1234_5678);    // fills the last slot
    add_req(bdq_pkg::REQ_PUSH_FRONT, 32'sh0bad_f00d);   // dropped, deque full
    add_req(bdq_pkg::REQ_PUSH_BACK, 32'sh0bad_f00d);    // dropped, deque full
    add_req(bdq_pkg::REQ_DUMP, '0);                      // longest dump
    add_req(bdq_pkg::REQ_POP_FRONT, '0);

    // random: runs of 20 beats leaning towards filling, draining or neither,
    // so that both the full and the empty corners come round again and again
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 20 == 0) begin
        mode    = $urandom_range(0, 2);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      case (mode)
        0:       req = (r < 65) ? bdq_pkg::REQ_PUSH_FRONT :
                       (r < 85) ? bdq_pkg::REQ_POP_FRONT : bdq_pkg::REQ_DUMP;
        1:       req = (r < 25) ? bdq_pkg::REQ_PUSH_FRONT :
                       (r < 85) ? bdq_pkg::REQ_POP_FRONT : bdq_pkg::REQ_DUMP;
        default: req = (r < 45) ? bdq_pkg::REQ_PUSH_FRONT :
                       (r < 85) ? bdq_pkg::REQ_POP_FRONT : bdq_pkg::REQ_DUMP;
      endcase
      // either push end
      if (req == bdq_pkg::REQ_PUSH_FRONT && $urandom_range(0, 1)) begin
        req = bdq_pkg::REQ_PUSH_BACK;
      end
      add_req(req, (req == bdq_pkg::REQ_PUSH_FRONT || req == bdq_pkg::REQ_PUSH_BACK) ?
                   pick_value() : $urandom);
    end

    // reset held low from the start, released once
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all request beats taken, then all result beats seen, then a quiet spell
    while (n_accepted != n_issued) @(posedge clk_i);
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
